// ===== design/dprm_pkg.sv =====
// dprm_pkg: shared types, widths and constants of the debounced press rate meter.
// Used by every module of the block and by its port checker.
// No dependencies.
package dprm_pkg;

    localparam int LOG_DEPTH = 256;
    localparam int LOG_AW    = $clog2(LOG_DEPTH);
    localparam int FILL_W    = $clog2(LOG_DEPTH + 1);

    localparam int TS_W      = 63;
    localparam int OP_W      = TS_W + 1;
    localparam int REG_W     = 40;
    localparam int RATE_W    = 9;
    localparam int ST_W      = 2;
    localparam int BTN_W     = 1;
    localparam int CODE_W    = 2;
    localparam int IDX_W     = 1;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 16;

    localparam logic [REG_W-1:0]  DEBOUNCE_RST = REG_W'(64'd200000000);
    localparam logic [REG_W-1:0]  WINDOW_RST   = REG_W'(64'd10000000000);
    localparam logic [RATE_W-1:0] RATE_MAX     = '1;

    typedef enum logic [ST_W-1:0] {
        ST_ACCEPT = 2'd0,
        ST_BOUNCE = 2'd1,
        ST_SAME   = 2'd2
    } status_t;

    typedef enum logic [IDX_W-1:0] {
        REG_DEBOUNCE = 1'b0,
        REG_WINDOW   = 1'b1
    } reg_idx_t;

    // log memory access, sequencer to RAM
    typedef struct packed {
        logic              we;
        logic [LOG_AW-1:0] waddr;
        logic [TS_W-1:0]   wdata;
        logic              re;
        logic [LOG_AW-1:0] raddr;
    } ram_req_t;

endpackage

// ===== design/debounced_press_rate_meter_unit.sv =====
// debounced_press_rate_meter_unit: top level, sequencer around one shared subtractor.
// Depends on dprm_pkg, dprm_sub_unit and dprm_log_ram.
//
// Usage:
//   Input words (s_*) carry one button press: s_tuser is the button id,
//   s_tdata the 63-bit nanosecond timestamp. Output words (m_*) carry one
//   result per press: m_tuser is the status (accepted, bounce, same button),
//   m_tdata the press count inside the sliding window.
//   cfg_we/cfg_addr/cfg_wdata write the debounce time (index 0) or the window
//   length (index 1), both in ns; write only while no press is in flight.
// Sequence:
//   A press walks gap check, debounce check, cutoff, then a scan of every
//   logged entry through the log RAM's single read port, one entry per cycle.
//   Rejected presses go from the gap or debounce check straight to the
//   done state, which loads the result word once the output register is free.
//   s_tready is high only while the sequencer is idle, so with no stall the
//   next press is taken in the cycle after the result word is loaded.
// Reset:
//   aresetn (synchronous, active low) clears the log fill/head, last press
//   time and button, held rate, and restores the register defaults. Log RAM
//   contents are not cleared; only entries below the fill count are read.
// Back-pressure:
//   The result word holds in an output register while m_tready is low; a new
//   press may be taken meanwhile and finishes into a wait state until the
//   register frees up.
module debounced_press_rate_meter_unit
    import dprm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [62:0] timestamp_ns, [63] zero
    input  logic [BTN_W-1:0]     s_tuser,   // [0] button
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [8:0] rate, [15:9] zero
    output logic [ST_W-1:0]      m_tuser,   // [1:0] status
    // register writes
    input  logic                 cfg_we,
    input  logic [IDX_W-1:0]     cfg_addr,
    input  logic [REG_W-1:0]     cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GAP,
        S_DEB,
        S_CUT,
        S_SCAN,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;

    // configuration
    logic [REG_W-1:0]    debounce_reg, debounce_next;
    logic [REG_W-1:0]    window_reg, window_next;

    // persistent state
    logic [TS_W-1:0]     last_time_reg, last_time_next;
    logic [CODE_W-1:0]   last_button_reg, last_button_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [LOG_AW-1:0]   head_reg, head_next;
    logic [RATE_W-1:0]   rate_reg, rate_next;

    // per-press working registers
    logic [TS_W-1:0]     now_reg, now_next;
    logic [CODE_W-1:0]   code_reg, code_next;
    logic [OP_W-1:0]     diff_reg, diff_next;
    logic [TS_W-1:0]     cutoff_reg, cutoff_next;
    logic                all_reg, all_next;
    logic [FILL_W-1:0]   idx_reg, idx_next;
    logic                pend_reg, pend_next;
    logic [RATE_W-1:0]   count_reg, count_next;
    status_t             status_reg, status_next;

    // output register
    logic                m_tvalid_reg, m_tvalid_next;
    logic [RATE_W-1:0]   m_rate_reg, m_rate_next;
    status_t             m_status_reg, m_status_next;

    // shared unit and log RAM
    logic [OP_W-1:0]     op_a, op_b, sub_diff;
    logic                sub_ge;
    ram_req_t            ram_req;
    logic [TS_W-1:0]     ram_rd_data;

    dprm_sub_unit u_sub (
        .op_a (op_a),
        .op_b (op_b),
        .diff (sub_diff),
        .ge   (sub_ge)
    );

    dprm_log_ram u_log (
        .aclk    (aclk),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    // operand select for the shared subtractor
    always_comb begin
        unique case (state_reg)
            S_GAP: begin
                op_a = OP_W'(now_reg);
                op_b = OP_W'(last_time_reg);
            end
            S_DEB: begin
                op_a = diff_reg;
                op_b = OP_W'(debounce_reg);
            end
            S_CUT: begin
                op_a = OP_W'(now_reg);
                op_b = OP_W'(window_reg);
            end
            S_SCAN: begin
                op_a = OP_W'(ram_rd_data);
                op_b = OP_W'(cutoff_reg);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next       = state_reg;
        debounce_next    = debounce_reg;
        window_next      = window_reg;
        last_time_next   = last_time_reg;
        last_button_next = last_button_reg;
        fill_next        = fill_reg;
        head_next        = head_reg;
        rate_next        = rate_reg;
        now_next         = now_reg;
        code_next        = code_reg;
        diff_next        = diff_reg;
        cutoff_next      = cutoff_reg;
        all_next         = all_reg;
        idx_next         = idx_reg;
        pend_next        = pend_reg;
        count_next       = count_reg;
        status_next      = status_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_rate_next      = m_rate_reg;
        m_status_next    = m_status_reg;

        ram_req.we    = 1'b0;
        ram_req.waddr = head_reg;
        ram_req.wdata = now_reg;
        ram_req.re    = 1'b0;
        ram_req.raddr = idx_reg[LOG_AW-1:0];

        if (cfg_we) begin
            unique case (reg_idx_t'(cfg_addr))
                REG_DEBOUNCE: debounce_next = cfg_wdata;
                REG_WINDOW:   window_next   = cfg_wdata;
            endcase
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    now_next   = s_tdata[TS_W-1:0];
                    code_next  = CODE_W'(s_tuser) + CODE_W'(1);
                    state_next = S_GAP;
                end
            end
            S_GAP: begin
                // time going backwards counts as a bounce
                diff_next = sub_diff;
                if (!sub_ge) begin
                    status_next = ST_BOUNCE;
                    state_next  = S_DONE;
                end else begin
                    state_next  = S_DEB;
                end
            end
            S_DEB: begin
                if (!sub_ge) begin
                    status_next = ST_BOUNCE;
                    state_next  = S_DONE;
                end else begin
                    last_time_next = now_reg;
                    if (code_reg == last_button_reg) begin
                        status_next = ST_SAME;
                        state_next  = S_DONE;
                    end else begin
                        last_button_next = code_reg;
                        ram_req.we       = 1'b1;
                        head_next        = (head_reg == LOG_AW'(LOG_DEPTH - 1)) ?
                                           '0 : head_reg + LOG_AW'(1);
                        if (fill_reg != FILL_W'(LOG_DEPTH)) begin
                            fill_next = fill_reg + FILL_W'(1);
                        end
                        state_next = S_CUT;
                    end
                end
            end
            S_CUT: begin
                // window reaching before zero: everything counts
                all_next    = ~sub_ge;
                cutoff_next = sub_diff[TS_W-1:0];
                idx_next    = '0;
                pend_next   = 1'b0;
                count_next  = '0;
                state_next  = S_SCAN;
            end
            S_SCAN: begin
                if (pend_reg && (all_reg || sub_ge) && count_reg != RATE_MAX) begin
                    count_next = count_reg + RATE_W'(1);
                end
                if (idx_reg < fill_reg) begin
                    ram_req.re = 1'b1;
                    idx_next   = idx_reg + FILL_W'(1);
                    pend_next  = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        rate_next   = count_reg;
                        status_next = ST_ACCEPT;
                        state_next  = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_rate_next   = rate_reg;
                    m_status_next = status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            debounce_reg    <= DEBOUNCE_RST;
            window_reg      <= WINDOW_RST;
            last_time_reg   <= '0;
            last_button_reg <= '0;
            fill_reg        <= '0;
            head_reg        <= '0;
            rate_reg        <= '0;
            pend_reg        <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            debounce_reg    <= debounce_next;
            window_reg      <= window_next;
            last_time_reg   <= last_time_next;
            last_button_reg <= last_button_next;
            fill_reg        <= fill_next;
            head_reg        <= head_next;
            rate_reg        <= rate_next;
            pend_reg        <= pend_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
        // payload, no reset
        now_reg      <= now_next;
        code_reg     <= code_next;
        diff_reg     <= diff_next;
        cutoff_reg   <= cutoff_next;
        all_reg      <= all_next;
        idx_reg      <= idx_next;
        count_reg    <= count_next;
        status_reg   <= status_next;
        m_rate_reg   <= m_rate_next;
        m_status_reg <= m_status_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - RATE_W){1'b0}}, m_rate_reg};
    assign m_tuser  = m_status_reg;

endmodule

// ===== design/dprm_log_ram.sv =====
// dprm_log_ram: circular press-time log, one write and one registered read port.
// Depends on dprm_pkg.
module dprm_log_ram
    import dprm_pkg::*;
(
    input  logic            aclk,
    input  ram_req_t        req,
    output logic [TS_W-1:0] rd_data
);

    logic [TS_W-1:0] mem [LOG_DEPTH];
    logic [TS_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/dprm_sub_unit.sv =====
// dprm_sub_unit: shared subtract/compare unit, a - b and a >= b (unsigned).
// Depends on dprm_pkg.
module dprm_sub_unit
    import dprm_pkg::*;
(
    input  logic [OP_W-1:0] op_a,
    input  logic [OP_W-1:0] op_b,
    output logic [OP_W-1:0] diff,
    output logic            ge
);

    logic [OP_W:0] wide;

    assign wide = {1'b0, op_a} - {1'b0, op_b};
    assign diff = wide[OP_W-1:0];
    assign ge   = ~wide[OP_W];

endmodule

// ===== design/dprm_port_checker.sv =====
// dprm_port_checker: port-level assertions for the press rate meter, plus bind.
// Depends on dprm_pkg and debounced_press_rate_meter_unit.
module dprm_port_checker
    import dprm_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [ST_W-1:0]      m_tuser
);

    // no result word survives reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // one press in flight: busy right after a word is taken
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a press is in flight");

    // status is a defined code and rate fits the log
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_ACCEPT || m_tuser == ST_BOUNCE || m_tuser == ST_SAME))
        else $error("undefined status code");

    a_rate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata <= M_TDATA_W'(LOG_DEPTH))
        else $error("rate exceeds log depth");

endmodule

bind debounced_press_rate_meter_unit dprm_port_checker u_dprm_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
